### rtl/nads_pkg.sv
package nads_pkg;

  // Fixed field widths of the stream beats
  localparam int FIELD_W     = 16;
  localparam int SLOT_W      = 9;
  localparam int IDX_OUT_W   = 9;
  localparam int SCORE_W     = 32;
  localparam int NUM_DIRS_W  = 10;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 48;

  // Bit offsets inside s_tdata
  localparam int SLOT_LSB = 0;
  localparam int X_LSB    = SLOT_LSB + SLOT_W;
  localparam int Y_LSB    = X_LSB + FIELD_W;
  localparam int Z_LSB    = Y_LSB + FIELD_W;

  localparam logic [NUM_DIRS_W-1:0] NUM_DIRS_RESET = NUM_DIRS_W'(1);

  // Input beat kinds carried on s_tuser
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  // Control that travels with each table entry down the cell row
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } beat_ctl_t;

endpackage

### rtl/nads_ram.sv
module nads_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/nads_mac_cell.sv
module nads_mac_cell #(
  parameter int CW  = 16,
  parameter int AW  = 34,
  parameter int IW  = 9,
  parameter int SEL = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_load,
  input  logic signed [CW-1:0]   q_in,
  input  nads_pkg::beat_ctl_t    ctl_in,
  input  logic [IW-1:0]          idx_in,
  input  logic [3*CW-1:0]        dir_in,
  input  logic signed [AW-1:0]   acc_in,
  output nads_pkg::beat_ctl_t    ctl_out,
  output logic [IW-1:0]          idx_out,
  output logic [3*CW-1:0]        dir_out,
  output logic signed [AW-1:0]   acc_out
);
  import nads_pkg::*;

  logic signed [CW-1:0]   q;
  logic signed [CW-1:0]   d_comp;
  logic signed [2*CW-1:0] prod;

  // one query component per cell, multiplied by the matching table component
  assign d_comp = dir_in[SEL*CW +: CW];
  assign prod   = q * d_comp;

  always_ff @(posedge clk) begin
    if (q_load) begin
      q <= q_in;
    end
    idx_out <= idx_in;
    dir_out <= dir_in;
    acc_out <= acc_in + AW'(prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

endmodule

### rtl/nearest_axis_direction_search_unit.sv
// Load beat: writes one table row if its slot is below MAX_DIRS, no result.
// Query beat: the table is scanned one row per cycle; the result passes
// the RAM read, three MAC cells, compare and output register. Next beat is
// taken only after the result enters the output register, which waits
// while the previous result is still held by the sink.
// Throughput is set by the single RAM read port: one row per cycle.
// rst (sync, high) clears control and sets num_dirs to 1; table is not cleared.
module nearest_axis_direction_search_unit #(
  parameter int MAX_DIRS  = 512,
  parameter int COMP_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // load/query beats
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // [8:0] slot, [24:9] dir_x, [40:25] dir_y, [56:41] dir_z, [63:57] zero
  input  logic [nads_pkg::IN_TDATA_W-1:0]        s_tdata,
  // [0] action
  input  logic [0:0]                             s_tuser,
  // result beats
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // [8:0] best_index, [40:9] best_score, [47:41] zero
  output logic [nads_pkg::OUT_TDATA_W-1:0]       m_tdata,
  // num_dirs register write
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [nads_pkg::NUM_DIRS_W-1:0]        cfg_data
);
  import nads_pkg::*;

  // widths
  localparam int IW    = (MAX_DIRS > 1) ? $clog2(MAX_DIRS) : 1;
  localparam int CW    = COMP_BITS;
  localparam int AW    = 2 * COMP_BITS + 2;      // signed sum of three products
  localparam int CNTW  = $clog2(MAX_DIRS + 1);
  localparam int CMPW  = (CNTW > NUM_DIRS_W) ? CNTW : NUM_DIRS_W;
  localparam int SLW   = ((IW > SLOT_W) ? IW : SLOT_W) + 1;
  localparam int EXT_W = (CW > FIELD_W) ? CW : FIELD_W;
  localparam int MW    = (AW > SCORE_W) ? AW : SCORE_W;
  localparam int IXW   = (IW > IDX_OUT_W) ? IW : IDX_OUT_W;

  // ---------------------------------------------------------------------
  // Input beat decode
  // ---------------------------------------------------------------------
  logic [EXT_W-1:0]     x_ext, y_ext, z_ext;
  logic signed [CW-1:0] in_x, in_y, in_z;
  logic [SLW-1:0]       slot_w;
  logic                 slot_ok;
  logic                 s_fire;
  logic                 is_query;
  logic                 is_load;

  // component = low COMP_BITS bits of the zero-extended field, read as signed
  assign x_ext = EXT_W'(s_tdata[X_LSB +: FIELD_W]);
  assign y_ext = EXT_W'(s_tdata[Y_LSB +: FIELD_W]);
  assign z_ext = EXT_W'(s_tdata[Z_LSB +: FIELD_W]);
  assign in_x  = $signed(x_ext[CW-1:0]);
  assign in_y  = $signed(y_ext[CW-1:0]);
  assign in_z  = $signed(z_ext[CW-1:0]);

  assign slot_w   = SLW'(s_tdata[SLOT_LSB +: SLOT_W]);
  assign slot_ok  = (slot_w < SLW'(MAX_DIRS));
  assign s_fire   = s_tvalid && s_tready;
  assign is_query = s_fire && (s_tuser[0] == ACT_QUERY);
  assign is_load  = s_fire && (s_tuser[0] == ACT_LOAD);

  // ---------------------------------------------------------------------
  // num_dirs register, always writable
  // ---------------------------------------------------------------------
  logic [NUM_DIRS_W-1:0] num_dirs;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_dirs <= NUM_DIRS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      num_dirs <= cfg_data;
    end
  end

  // last address of a scan: num_dirs clamped to 1..MAX_DIRS, minus one
  logic [CMPW-1:0] nd_w;
  logic [CMPW-1:0] nd_clamp;
  logic [CMPW-1:0] nd_last;
  logic [IW-1:0]   last_addr;

  assign nd_w = CMPW'(num_dirs);

  always_comb begin
    if (nd_w == '0) begin
      nd_clamp = CMPW'(1);
    end else if (nd_w > CMPW'(MAX_DIRS)) begin
      nd_clamp = CMPW'(MAX_DIRS);
    end else begin
      nd_clamp = nd_w;
    end
  end

  assign nd_last = nd_clamp - CMPW'(1);

  always_ff @(posedge clk) begin
    if (is_query) begin
      last_addr <= nd_last[IW-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  state_t        state, state_next;
  logic [IW-1:0] cnt;
  logic          scan_last;
  logic          fin;          // compare stage has seen the last row
  logic          out_free;
  logic          out_load;
  beat_ctl_t     issue;

  assign scan_last = (cnt == last_addr);
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (is_query) begin
                  state_next = ST_SCAN;
                end
      ST_SCAN:  if (scan_last) begin
                  state_next = ST_DRAIN;
                end
      ST_DRAIN: if (fin && out_free) begin
                  state_next = ST_IDLE;
                end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    out_load    = 1'b0;
    issue       = '0;
    case (state)
      ST_IDLE:  s_tready = 1'b1;
      ST_SCAN:  begin
        issue.valid = 1'b1;
        issue.first = (cnt == '0);
        issue.last  = scan_last;
      end
      ST_DRAIN: out_load = fin && out_free;
      default:  s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == ST_SCAN) begin
      cnt <= scan_last ? '0 : cnt + IW'(1);
    end else begin
      cnt <= '0;
    end
  end

  // ---------------------------------------------------------------------
  // Direction table: written by load beats, read one row per scan cycle
  // ---------------------------------------------------------------------
  logic [3*CW-1:0] rd_dir;
  beat_ctl_t       rd_ctl;
  logic [IW-1:0]   rd_idx;

  nads_ram #(
    .WIDTH (3 * CW),
    .DEPTH (MAX_DIRS),
    .AW    (IW)
  ) u_table (
    .clk   (clk),
    .we    (is_load && slot_ok),
    .waddr (slot_w[IW-1:0]),
    .wdata ({in_z, in_y, in_x}),
    .raddr (cnt),
    .rdata (rd_dir)
  );

  // control/index aligned with the registered RAM read
  always_ff @(posedge clk) begin
    rd_idx <= cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ctl <= '0;
    end else begin
      rd_ctl <= issue;
    end
  end

  // ---------------------------------------------------------------------
  // Row of MAC cells: cell k holds query component k and adds q_k * d_k
  // to the running sum handed down from cell k-1.
  // ---------------------------------------------------------------------
  beat_ctl_t            c_ctl [4];
  logic [IW-1:0]        c_idx [4];
  logic [3*CW-1:0]      c_dir [4];
  logic signed [AW-1:0] c_acc [4];
  logic signed [CW-1:0] q_comp [3];

  assign q_comp[0] = in_x;
  assign q_comp[1] = in_y;
  assign q_comp[2] = in_z;

  assign c_ctl[0] = rd_ctl;
  assign c_idx[0] = rd_idx;
  assign c_dir[0] = rd_dir;
  assign c_acc[0] = '0;

  for (genvar k = 0; k < 3; k++) begin : g_cell
    nads_mac_cell #(
      .CW  (CW),
      .AW  (AW),
      .IW  (IW),
      .SEL (k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .q_load  (is_query),
      .q_in    (q_comp[k]),
      .ctl_in  (c_ctl[k]),
      .idx_in  (c_idx[k]),
      .dir_in  (c_dir[k]),
      .acc_in  (c_acc[k]),
      .ctl_out (c_ctl[k+1]),
      .idx_out (c_idx[k+1]),
      .dir_out (c_dir[k+1]),
      .acc_out (c_acc[k+1])
    );
  end

  // ---------------------------------------------------------------------
  // Running max of |sum|; strict greater keeps the lowest index on ties
  // ---------------------------------------------------------------------
  logic [AW-1:0] mag;
  logic [AW-1:0] best_mag;
  logic [IW-1:0] best_idx;
  logic          take;

  assign mag  = c_acc[3][AW-1] ? AW'(-c_acc[3]) : AW'(c_acc[3]);
  assign take = c_ctl[3].valid && (c_ctl[3].first || (mag > best_mag));

  always_ff @(posedge clk) begin
    if (take) begin
      best_mag <= mag;
      best_idx <= c_idx[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin <= 1'b0;
    end else if (out_load) begin
      fin <= 1'b0;
    end else if (c_ctl[3].valid && c_ctl[3].last) begin
      fin <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Output register: score saturates to 32 bits, index masked to 9 bits
  // ---------------------------------------------------------------------
  logic [MW-1:0]        mag_w;
  logic [SCORE_W-1:0]   score;
  logic [IXW-1:0]       idx_w;
  logic [IDX_OUT_W-1:0] idx_out;

  assign mag_w   = MW'(best_mag);
  assign score   = (mag_w > MW'({SCORE_W{1'b1}})) ? {SCORE_W{1'b1}} : mag_w[SCORE_W-1:0];
  assign idx_w   = IXW'(best_idx);
  assign idx_out = idx_w[IDX_OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= OUT_TDATA_W'({score, idx_out});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule
